>>> rtl/core/sample_statistics_mean_min_max_std_assert.svh
// Assertion macros for the sample statistics RTL.
`ifndef SAMPLE_STATISTICS_MEAN_MIN_MAX_STD_ASSERT_SVH
`define SAMPLE_STATISTICS_MEAN_MIN_MAX_STD_ASSERT_SVH

// Antecedent true implies consequent in the same cycle.
`define SSMMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent true implies consequent in the next cycle.
`define SSMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/ssmms_pkg.sv
// Package with constants and control types of the sample statistics block.
`default_nettype none
package ssmms_pkg;
	localparam int unsigned MAX_SAMPLES = 255;
	localparam int unsigned MUL_STEPS   = 8;
	localparam int unsigned MEAN_STEPS  = 24;
	localparam int unsigned VAR_STEPS   = 48;
	localparam int unsigned SQRT_STEPS  = 16;
	localparam int unsigned STEP_W      = 6;

	typedef struct packed {
		logic cap;
		logic acc;
		logic mul_load;
		logic mul_step;
		logic sub;
		logic div_mean;
		logic mean_cap;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic finish;
	} cmd_t;
endpackage
`default_nettype wire

>>> rtl/core/ssmms_dp.sv
// Datapath: accumulators, serial multiplier, shared divider, square root.
`default_nettype none
module ssmms_dp (
	input  wire logic            clk,
	input  wire ssmms_pkg::cmd_t cmd,
	input  wire logic [3:0]      sensor,
	input  wire logic [15:0]     sample,
	output logic      [3:0]      sensor_out,
	output logic      [7:0]      sample_count,
	output logic      [15:0]     mean,
	output logic      [15:0]     minimum,
	output logic      [15:0]     maximum,
	output logic      [15:0]     std_dev,
	output logic                 overflow,
	input  wire logic            arst_n
);
	logic [3:0]  sensor_q;
	logic [15:0] sample_q;
	logic [7:0]  count_q;
	logic [23:0] sum_q;
	logic [39:0] sqsum_q;
	logic [15:0] min_q, max_q;
	logic        ovf_q;
	logic [7:0]  nsh_q;
	logic [47:0] prod_q, sq_q, num_q, divd_q;
	logic [15:0] nn_q, divr_q, rem_q, mean_q;
	logic [31:0] rad_q;
	logic [16:0] srem_q;
	logic [15:0] root_q;

	logic [31:0] xsq;
	logic [47:0] sq_c, prod_next;
	logic [15:0] nn_c;
	logic [16:0] r2, rsub;
	logic        d_ge;
	logic [18:0] s2, trial, ssub;
	logic        s_ge;
	logic [15:0] root_next;

	assign xsq       = {16'b0, sample_q} * {16'b0, sample_q};
	assign sq_c      = {24'b0, sum_q} * {24'b0, sum_q};
	assign nn_c      = {8'b0, count_q} * {8'b0, count_q};
	assign prod_next = {prod_q[46:0], 1'b0} + (nsh_q[7] ? {8'b0, sqsum_q} : 48'b0);
	assign r2        = {rem_q, divd_q[47]};
	assign rsub      = r2 - {1'b0, divr_q};
	assign d_ge      = r2 >= {1'b0, divr_q};
	assign s2        = {srem_q, rad_q[31:30]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign ssub      = s2 - trial;
	assign s_ge      = s2 >= trial;
	assign root_next = {root_q[14:0], s_ge};

	// Accumulators; finish clears them back to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.finish) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.acc) begin
			if (count_q < 8'(ssmms_pkg::MAX_SAMPLES)) begin
				count_q <= count_q + 8'd1;
				sum_q   <= sum_q + {8'b0, sample_q};
				sqsum_q <= sqsum_q + {8'b0, xsq};
				if (sample_q < min_q) min_q <= sample_q;
				if (sample_q > max_q) max_q <= sample_q;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			sensor_q <= sensor;
			sample_q <= sample;
		end
		if (cmd.mul_load) begin
			nsh_q  <= count_q;
			prod_q <= '0;
			sq_q   <= sq_c;
			nn_q   <= nn_c;
		end
		if (cmd.mul_step) begin
			prod_q <= prod_next;
			nsh_q  <= {nsh_q[6:0], 1'b0};
		end
		if (cmd.sub) num_q <= (prod_q >= sq_q) ? prod_q - sq_q : 48'b0;
		if (cmd.div_mean) begin
			divd_q <= {sum_q, 24'b0};
			divr_q <= {8'b0, count_q};
			rem_q  <= '0;
		end
		if (cmd.mean_cap) begin
			mean_q <= divd_q[15:0];
			divd_q <= num_q;
			divr_q <= nn_q;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= d_ge ? rsub[15:0] : r2[15:0];
			divd_q <= {divd_q[46:0], d_ge};
		end
		if (cmd.sqrt_load) begin
			rad_q  <= divd_q[31:0];
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			srem_q <= s_ge ? ssub[16:0] : s2[16:0];
			root_q <= root_next;
		end
		// Latch the result beat on the last square root step.
		if (cmd.finish) begin
			sensor_out   <= sensor_q;
			sample_count <= count_q;
			mean         <= mean_q;
			minimum      <= min_q;
			maximum      <= max_q;
			std_dev      <= root_next;
			overflow     <= ovf_q;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/ssmms_ctrl.sv
// Controller state machine sequencing accumulate and final computation.
`default_nettype none
`include "sample_statistics_mean_min_max_std_assert.svh"
module ssmms_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            last,
	output logic                 busy,
	output logic                 done,
	output ssmms_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_ACC, S_MLD, S_MUL, S_SUB, S_DIVM, S_MCAP, S_DIVV, S_SLD, S_SQRT
	} state_t;

	state_t                           state_q;
	logic [ssmms_pkg::STEP_W-1:0]     cnt_q;
	logic                             last_q;
	logic                             accept;

	assign accept = start && !busy;

	always_comb begin
		cmd           = '0;
		cmd.cap       = accept;
		cmd.acc       = (state_q == S_ACC);
		cmd.mul_load  = (state_q == S_MLD);
		cmd.mul_step  = (state_q == S_MUL);
		cmd.sub       = (state_q == S_SUB);
		cmd.div_mean  = (state_q == S_SUB);
		cmd.mean_cap  = (state_q == S_MCAP);
		cmd.div_step  = (state_q == S_DIVM) || (state_q == S_DIVV);
		cmd.sqrt_load = (state_q == S_SLD);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.finish    = (state_q == S_SQRT) &&
			(cnt_q == ssmms_pkg::STEP_W'(ssmms_pkg::SQRT_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done  <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= last;
						busy    <= 1'b1;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (last_q) begin
						state_q <= S_MLD;
					end else begin
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_MLD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == ssmms_pkg::STEP_W'(ssmms_pkg::MUL_STEPS - 1)) state_q <= S_SUB;
				end
				S_SUB: begin
					cnt_q   <= '0;
					state_q <= S_DIVM;
				end
				S_DIVM: begin
					if (cnt_q == ssmms_pkg::STEP_W'(ssmms_pkg::MEAN_STEPS - 1)) state_q <= S_MCAP;
				end
				S_MCAP: begin
					cnt_q   <= '0;
					state_q <= S_DIVV;
				end
				S_DIVV: begin
					if (cnt_q == ssmms_pkg::STEP_W'(ssmms_pkg::VAR_STEPS - 1)) state_q <= S_SLD;
				end
				S_SLD: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cmd.finish) begin
						done    <= 1'b1;
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SSMMS_ASSERT_NEXT(a_finish_done, clk, arst_n, cmd.finish, done && state_q == S_IDLE)
	`SSMMS_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy && state_q == S_IDLE)
	`SSMMS_ASSERT_NEXT(a_accept_acc, clk, arst_n, accept, busy && state_q == S_ACC)
	`SSMMS_ASSERT_SAME(a_busy_state, clk, arst_n, busy, state_q != S_IDLE)
endmodule
`default_nettype wire

>>> rtl/core/sample_statistics_mean_min_max_std.sv
// Top level of the sample statistics block: count, mean, min, max, std dev.
//
// Usage:
//   Drive sensor, sample and last with start high; the beat is taken at a
//   rising edge where start is high and busy is low. Hold start until then.
//   A beat with last low is accumulated and busy is high for one cycle,
//   so the next plain sample is taken only once busy is low again.
//   A beat with last high closes the set: the controller runs an 8 step
//   serial multiply (n * sum of squares), then a 24 step division for the
//   mean and a 48 step division for the variance, both on the shared
//   divider, and a 16 step square root. done pulses for one cycle once the
//   square root is through, with the result on the output ports; the
//   output ports keep that result until the next result beat.
//   The receiver cannot stall: capture the result in the cycle done is high.
//   Samples arriving once the count has reached its capacity are dropped
//   and flagged through overflow. The accumulators clear after each result.
//   Reset (arst_n low) clears the accumulators and returns to idle at once.
`default_nettype none
module sample_statistics_mean_min_max_std (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  sensor,
	input  wire logic [15:0] sample,
	input  wire logic        last,
	output logic             done,
	output logic      [3:0]  sensor_out,
	output logic      [7:0]  sample_count,
	output logic      [15:0] mean,
	output logic      [15:0] minimum,
	output logic      [15:0] maximum,
	output logic      [15:0] std_dev,
	output logic             overflow
);
	ssmms_pkg::cmd_t cmd;

	// Sequence accumulate and final steps.
	ssmms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold accumulators and the arithmetic units.
	ssmms_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sensor       (sensor),
		.sample       (sample),
		.sensor_out   (sensor_out),
		.sample_count (sample_count),
		.mean         (mean),
		.minimum      (minimum),
		.maximum      (maximum),
		.std_dev      (std_dev),
		.overflow     (overflow),
		.arst_n       (arst_n)
	);
endmodule
`default_nettype wire

>>> tb/sv/sample_statistics_mean_min_max_std_tb.sv
// Self-checking testbench for the sample statistics block: directed sets, overflow, random sets.
`timescale 1ns / 100ps
`default_nettype none
module sample_statistics_mean_min_max_std_tb;
	// Expected content of one result beat.
	typedef struct packed {
		logic [3:0]  sensor;
		logic [7:0]  count;
		logic [15:0] mean;
		logic [15:0] minimum;
		logic [15:0] maximum;
		logic [15:0] std_dev;
		logic        overflow;
	} stats_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  sensor;
	logic [15:0] sample;
	logic        last;
	logic        done;
	logic [3:0]  sensor_out;
	logic [7:0]  sample_count;
	logic [15:0] mean;
	logic [15:0] minimum;
	logic [15:0] maximum;
	logic [15:0] std_dev;
	logic        overflow;

	// Predictor state, mirrors the accumulators of the block.
	logic [7:0]  acc_count;
	logic [23:0] acc_sum;
	logic [39:0] acc_sqsum;
	logic [15:0] acc_min;
	logic [15:0] acc_max;
	logic        acc_ovf;

	stats_t pending_stats[$];
	int     fail_count;

	sample_statistics_mean_min_max_std u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sensor(sensor), .sample(sample), .last(last), .done(done),
		.sensor_out(sensor_out), .sample_count(sample_count), .mean(mean),
		.minimum(minimum), .maximum(maximum), .std_dev(std_dev),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitpos;
		root = '0;
		bitpos = 64'd1 << 62;
		while (bitpos > v)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v = v - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	task automatic clear_accumulators();
		acc_count = '0;
		acc_sum = '0;
		acc_sqsum = '0;
		acc_min = 16'hFFFF;
		acc_max = '0;
		acc_ovf = 1'b0;
	endtask

	// Fold one accepted beat into the accumulators; on last, queue the statistics.
	task automatic accumulate_sample(input logic [3:0] s, input logic [15:0] x,
			input logic l);
		logic [63:0] n;
		logic [63:0] num;
		logic [63:0] sq;
		stats_t      st;
		if (acc_count < 8'(ssmms_pkg::MAX_SAMPLES)) begin
			acc_count = acc_count + 8'd1;
			acc_sum = acc_sum + {8'b0, x};
			acc_sqsum = acc_sqsum + 40'(64'(x) * 64'(x));
			if (x < acc_min)
				acc_min = x;
			if (x > acc_max)
				acc_max = x;
		end else begin
			acc_ovf = 1'b1;
		end
		if (l) begin
			n = 64'(acc_count);
			sq = 64'(acc_sum) * 64'(acc_sum);
			num = n * 64'(acc_sqsum);
			num = (num >= sq) ? num - sq : 64'd0;
			st.sensor = s;
			st.count = acc_count;
			st.mean = 16'(64'(acc_sum) / n);
			st.minimum = acc_min;
			st.maximum = acc_max;
			st.std_dev = 16'(floor_sqrt(num / (n * n)));
			st.overflow = acc_ovf;
			pending_stats.push_back(st);
			clear_accumulators();
		end
	endtask

	// Send one beat: hold start until busy is low at an edge, then drop it
	// for a random gap unless the next beat follows at once.
	task automatic send_sample(input logic [3:0] s, input logic [15:0] x, input logic l);
		int gap;
		start <= 1'b1;
		sensor <= s;
		sample <= x;
		last <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		accumulate_sample(s, x, l);
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4));
		if (gap > 0) begin
			start <= 1'b0;
			sensor <= 4'($urandom);
			sample <= 16'($urandom);
			last <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_set(input int n, input int mode);
		logic [3:0]  s;
		logic [15:0] x;
		s = 4'($urandom);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: x = 16'($urandom);
				1: x = 16'($urandom_range(0, 15));
				2: x = 16'($urandom_range(65520, 65535));
				default: x = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			endcase
			send_sample(s, x, i == n - 1);
		end
	endtask

	// Hold off until every result is out.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Extremes: single samples at zero and full scale, sensors 0 and F, a constant set.
	task automatic test_directed_extremes();
		send_sample(4'h0, 16'h0000, 1'b1);
		send_sample(4'hF, 16'hFFFF, 1'b1);
		send_sample(4'hA, 16'h5555, 1'b0);
		send_sample(4'h5, 16'hAAAA, 1'b1);
		send_sample(4'h3, 16'h0000, 1'b0);
		send_sample(4'h3, 16'hFFFF, 1'b0);
		send_sample(4'h3, 16'hFFFF, 1'b0);
		send_sample(4'hC, 16'h0000, 1'b1);
		for (int i = 0; i < 5; i++)
			send_sample(4'h9, 16'h1234, i == 4);
		send_sample(4'h1, 16'h0001, 1'b0);
		send_sample(4'h2, 16'h0002, 1'b1);
		drain_results();
	endtask

	// Capacity: exactly full, overflow on plain samples, overflow on the last beat.
	task automatic test_capacity_overflow();
		send_set(ssmms_pkg::MAX_SAMPLES, 3);
		drain_results();
		for (int i = 0; i < ssmms_pkg::MAX_SAMPLES + 3; i++)
			send_sample(4'h7, 16'hFFFF, i == ssmms_pkg::MAX_SAMPLES + 2);
		for (int i = 0; i < ssmms_pkg::MAX_SAMPLES + 1; i++)
			send_sample(4'hE, 16'($urandom), i == ssmms_pkg::MAX_SAMPLES);
		drain_results();
	endtask

	// Random sets, mostly short, a few long or near the edges of the range.
	task automatic test_random_sets();
		int sent;
		int n;
		sent = 0;
		while (sent < 650) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
			send_set(n, $urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 3));
			sent += n;
		end
		drain_results();
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		stats_t want;
		if (arst_n && done) begin
			if (pending_stats.size() == 0) begin
				$error("result beat with no expectation");
				fail_count++;
			end else begin
				want = pending_stats.pop_front();
				if (sensor_out !== want.sensor) begin
					$error("sensor_out exp %0d got %0d", want.sensor, sensor_out);
					fail_count++;
				end
				if (sample_count !== want.count) begin
					$error("sample_count exp %0d got %0d", want.count, sample_count);
					fail_count++;
				end
				if (mean !== want.mean) begin
					$error("mean exp %0d got %0d", want.mean, mean);
					fail_count++;
				end
				if (minimum !== want.minimum) begin
					$error("minimum exp %0d got %0d", want.minimum, minimum);
					fail_count++;
				end
				if (maximum !== want.maximum) begin
					$error("maximum exp %0d got %0d", want.maximum, maximum);
					fail_count++;
				end
				if (std_dev !== want.std_dev) begin
					$error("std_dev exp %0d got %0d", want.std_dev, std_dev);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow exp %0d got %0d", want.overflow, overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		clear_accumulators();
		arst_n = 1'b0;
		start = 1'b0;
		sensor = 4'h0;
		sample = 16'h0000;
		last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_capacity_overflow();
		test_random_sets();
		repeat (120) @(posedge clk);
		if (fail_count == 0 && pending_stats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Worst case roughly 1560 beats, each with the longest random gap and a full result computation.
	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
